/* hw/rtl/pfld_pkg.sv */
`timescale 1ns / 1ps

package pfld_pkg;

  // Default frame geometry
  localparam int WIDTH_DEF = 128;
  localparam int PAGES_DEF = 8;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int PAGE_W = 3;
  localparam int FUNC_W = 2;
  localparam int BYTE_W = 8;

  // Divider operand width, and the widths of the line stepping registers
  localparam int DIV_W = 7;
  localparam int POS_W = 9;
  localparam int SUM_W = DIV_W + 1;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LINE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Divider request and result
  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_res_t;

endpackage

/* hw/rtl/pfld_div.sv */
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
// den must be nonzero when go is raised.
module pfld_div (
  input  logic               clk,
  input  logic               rst,
  input  pfld_pkg::div_req_t req,
  output pfld_pkg::div_res_t res
);
  import pfld_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;

  // trial subtract of the divisor from the partial remainder
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        rem <= '0;
        quo <= req.num;
        den <= req.den;
        cnt <= CNT_W'(DIV_W);
        run <= 1'b1;
      end else if (run) begin
        if (!diff[DIV_W]) begin
          rem <= diff[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule

/* hw/rtl/page_framebuffer_line_drawer.sv */
`timescale 1ns / 1ps

// One-bit frame store of WIDTH columns by 8*PAGES rows, kept as PAGES pages of
// WIDTH column bytes (bit y%8 of page y/8 holds row y), with pixel write, line
// draw and byte read commands. A command is taken when start is high and busy
// is low; every command answers with exactly one done pulse, one cycle wide,
// and read_data carries the frame byte for a read and zero otherwise. The
// receiver cannot stall done, so it must take the word in that cycle. After
// reset the block sweeps the store to zero, one byte per cycle, and stays busy
// until every byte is cleared. The store has one read and one write port, and
// each pixel is a read-modify-write of its byte, which sets the pace: a
// vertical line takes one pass over its rows, and any other line an x pass
// over its columns plus a y pass over its rows, which is skipped when the
// line is horizontal; each of these two passes first uses the shared
// bit-serial divider to work out its slope.
module page_framebuffer_line_drawer #(
  parameter int WIDTH = pfld_pkg::WIDTH_DEF,
  parameter int PAGES = pfld_pkg::PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pfld_pkg::FUNC_W-1:0] func,
  input  logic [pfld_pkg::COL_W-1:0]  start_x,
  input  logic [pfld_pkg::ROW_W-1:0]  start_y,
  input  logic [pfld_pkg::COL_W-1:0]  end_x,
  input  logic [pfld_pkg::ROW_W-1:0]  end_y,
  input  logic                        pixel_on,
  input  logic [pfld_pkg::PAGE_W-1:0] read_page,
  input  logic [pfld_pkg::COL_W-1:0]  read_column,
  output logic                        done,
  output logic [pfld_pkg::BYTE_W-1:0] read_data
);
  import pfld_pkg::*;

  localparam int DEPTH  = WIDTH * PAGES;
  localparam int AW     = $clog2(DEPTH);
  localparam int CALC_W = $clog2(WIDTH) + 4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ADDR,
    S_RMW,
    S_OUT
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                            input logic [COL_W-1:0]  col);
    logic [CALC_W-1:0] full;
    full = CALC_W'(page) * CALC_W'(WIDTH) + CALC_W'(col);
    return full[AW-1:0];
  endfunction

  state_t                   state;
  logic [AW-1:0]            clr_addr;

  // latched command
  logic [COL_W-1:0]         x1;
  logic [ROW_W-1:0]         y1;
  logic [DIV_W-1:0]         adx;
  logic [ROW_W-1:0]         ady;
  logic                     dx_neg;
  logic                     dy_neg;
  logic                     on;
  logic                     rd_zero;

  // line stepping
  logic                     ymode;
  logic                     more_y;
  logic [COL_W-1:0]         step;
  logic                     dir_neg;
  logic signed [POS_W-1:0]  pos;
  logic signed [POS_W-1:0]  qd;
  logic [DIV_W-1:0]         rd;
  logic [DIV_W-1:0]         racc;
  logic [DIV_W-1:0]         den;
  logic [COL_W-1:0]         cnt;

  // pixel read-modify-write
  logic [AW-1:0]            pix_addr;
  logic [BYTE_W-1:0]        pix_mask;
  logic                     pix_ok;

  // frame store
  logic [BYTE_W-1:0]        mem [DEPTH];
  logic [BYTE_W-1:0]        mem_q;
  logic                     mem_we;
  logic                     mem_re;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic [BYTE_W-1:0]        mem_wdata;

  // combinational helpers
  logic [COL_W:0]           in_dx;
  logic [ROW_W:0]           in_dy;
  logic [DIV_W-1:0]         in_adx;
  logic [ROW_W-1:0]         in_ady;
  logic                     rd_ok;
  logic [COL_W-1:0]         cur_col;
  logic [ROW_W-1:0]         cur_row;
  logic [PAGE_W-1:0]        cur_page;
  logic                     cur_ok;
  logic [AW-1:0]            cur_addr;
  logic                     num_neg;
  logic [POS_W-1:0]         q_ext;
  logic signed [POS_W-1:0]  qd_calc;
  logic [DIV_W-1:0]         rd_calc;
  logic [SUM_W-1:0]         rsum;
  logic                     carry;
  logic [DIV_W-1:0]         racc_next;
  logic signed [POS_W-1:0]  pos_next;
  div_req_t                 div_req;
  div_res_t                 div_res;

  assign busy = (state != S_IDLE);

  // endpoint deltas from the command ports
  assign in_dx  = {1'b0, end_x} - {1'b0, start_x};
  assign in_dy  = {1'b0, end_y} - {1'b0, start_y};
  assign in_adx = in_dx[COL_W] ? DIV_W'(-in_dx) : in_dx[DIV_W-1:0];
  assign in_ady = in_dy[ROW_W] ? ROW_W'(-in_dy) : in_dy[ROW_W-1:0];
  assign rd_ok  = (int'(read_page) < PAGES) && (int'(read_column) < WIDTH);

  // current pixel: x pass steps the column, y pass steps the row
  assign cur_col  = ymode ? pos[COL_W-1:0] : step;
  assign cur_row  = ymode ? step[ROW_W-1:0] : pos[ROW_W-1:0];
  assign cur_page = cur_row[ROW_W-1:3];
  assign cur_ok   = (int'(cur_col) < WIDTH) && (int'(cur_page) < PAGES);
  assign cur_addr = addr_of(cur_page, cur_col);

  // floor division result as per-step whole and fractional increments
  assign num_neg = ymode ? dx_neg : dy_neg;
  assign q_ext   = POS_W'(div_res.quo);
  always_comb begin
    if (!num_neg) begin
      qd_calc = q_ext;
      rd_calc = div_res.rem;
    end else if (div_res.rem == '0) begin
      qd_calc = -q_ext;
      rd_calc = '0;
    end else begin
      qd_calc = -q_ext - POS_W'(1);
      rd_calc = den - div_res.rem;
    end
  end

  // fractional accumulator step
  assign rsum      = {1'b0, racc} + {1'b0, rd};
  assign carry     = (rsum >= {1'b0, den});
  assign racc_next = carry ? DIV_W'(rsum - {1'b0, den}) : rsum[DIV_W-1:0];
  assign pos_next  = pos + qd + POS_W'(carry);

  // divider requests: x pass slope on accept, y pass slope at end of x pass
  always_comb begin
    div_req = '0;
    if (state == S_IDLE && start && func == FUNC_LINE && in_dx != '0) begin
      div_req.go  = 1'b1;
      div_req.num = DIV_W'(in_ady);
      div_req.den = in_adx;
    end else if (state == S_RMW && cnt == '0 && more_y) begin
      div_req.go  = 1'b1;
      div_req.num = adx;
      div_req.den = DIV_W'(ady);
    end
  end

  pfld_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // frame store port control
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_RMW && pix_ok);
    mem_waddr = (state == S_CLEAR) ? clr_addr : pix_addr;
    if (state == S_CLEAR) begin
      mem_wdata = '0;
    end else if (on) begin
      mem_wdata = mem_q | pix_mask;
    end else begin
      mem_wdata = mem_q & ~pix_mask;
    end
    mem_re    = (state == S_ADDR && cur_ok) ||
                (state == S_IDLE && start && func == FUNC_READ && rd_ok);
    mem_raddr = (state == S_ADDR) ? cur_addr : addr_of(read_page, read_column);
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done      <= 1'b0;
      read_data <= '0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            x1     <= start_x;
            y1     <= start_y;
            adx    <= in_adx;
            ady    <= in_ady;
            dx_neg <= in_dx[COL_W];
            dy_neg <= in_dy[ROW_W];
            on     <= pixel_on;
            racc   <= '0;
            unique case (func)
              FUNC_PIXEL: begin
                ymode   <= 1'b0;
                more_y  <= 1'b0;
                step    <= start_x;
                pos     <= POS_W'(start_y);
                qd      <= '0;
                rd      <= '0;
                den     <= DIV_W'(1);
                cnt     <= '0;
                dir_neg <= 1'b0;
                state   <= S_ADDR;
              end
              FUNC_LINE: begin
                if (in_dx != '0) begin
                  ymode <= 1'b0;
                  den   <= in_adx;
                  state <= S_DIV;
                end else begin
                  // vertical: one pass over the rows at a fixed column
                  ymode   <= 1'b1;
                  more_y  <= 1'b0;
                  step    <= COL_W'(start_y);
                  pos     <= POS_W'(start_x);
                  qd      <= '0;
                  rd      <= '0;
                  den     <= DIV_W'(1);
                  cnt     <= COL_W'(in_ady);
                  dir_neg <= in_dy[ROW_W];
                  state   <= S_ADDR;
                end
              end
              FUNC_READ: begin
                rd_zero <= !rd_ok;
                state   <= S_OUT;
              end
              default: begin
                rd_zero <= 1'b1;
                state   <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            qd   <= qd_calc;
            rd   <= rd_calc;
            racc <= '0;
            if (ymode) begin
              step    <= COL_W'(y1);
              pos     <= POS_W'(x1);
              cnt     <= COL_W'(ady);
              dir_neg <= dy_neg;
              more_y  <= 1'b0;
            end else begin
              step    <= x1;
              pos     <= POS_W'(y1);
              cnt     <= adx;
              dir_neg <= dx_neg;
              more_y  <= (ady != '0);
            end
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          pix_addr <= cur_addr;
          pix_mask <= BYTE_W'(8'h01) << cur_row[2:0];
          pix_ok   <= cur_ok;
          state    <= S_RMW;
        end
        S_RMW: begin
          if (cnt == '0) begin
            if (more_y) begin
              ymode <= 1'b1;
              den   <= DIV_W'(ady);
              state <= S_DIV;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            cnt   <= cnt - COL_W'(1);
            step  <= dir_neg ? step - COL_W'(1) : step + COL_W'(1);
            racc  <= racc_next;
            pos   <= pos_next;
            state <= S_ADDR;
          end
        end
        S_OUT: begin
          done      <= 1'b1;
          read_data <= rd_zero ? '0 : mem_q;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/pfld_checker.sv */
`timescale 1ns / 1ps

module pfld_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [pfld_pkg::BYTE_W-1:0] read_data
);
  import pfld_pkg::*;

  // store sweep starts right out of reset
  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("not busy clearing after reset");

  // an accepted command always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // a result word ends a command that was in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a command in progress");

  // done leaves the block idle and no command ends straight from idle, so result words never abut
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high two cycles in a row");

  // result data is quiet between words
  a_data_quiet: assert property (@(posedge clk) disable iff (rst)
    (!done && !$past(rst)) |-> (read_data == '0))
    else $error("read_data nonzero outside done");

endmodule

bind page_framebuffer_line_drawer pfld_checker u_pfld_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .read_data (read_data)
);
